// ===== src/ac3_hdr_pkg.sv =====
// ----------------------------------------------------------------------------
// AC-3 header parser package
// Shared types, status codes and constant tables for the sync-info and
// bit-stream-info header parser.
// ----------------------------------------------------------------------------
package ac3_hdr_pkg;

    // Status codes of one header result.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EOS       = 2'd1;
    localparam logic [1:0] STATUS_BAD_RATE  = 2'd2;
    localparam logic [1:0] STATUS_BAD_SIZE  = 2'd3;

    // Header field limits.
    localparam logic [1:0] RATE_RESERVED    = 2'd3;
    localparam logic [5:0] MAX_SIZE_CODE    = 6'd37;

    // Default sync pattern and configuration port geometry.
    localparam logic [15:0] SYNC_WORD_RESET = 16'h0B77;
    localparam int          APB_ADDR_W      = 2;
    localparam int          APB_DATA_W      = 32;

    // Byte address of the sync word register.
    localparam logic [APB_ADDR_W-1:0] SYNC_WORD_ADDR = '0;

    // Audio coding modes that matter for the LFE bit position.
    localparam logic [2:0] ACMOD_MONO       = 3'd1;
    localparam logic [2:0] ACMOD_STEREO     = 3'd2;

    // One decoded header result.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] sampling_hz;
        logic [11:0] frame_bytes;
        logic [2:0]  channel_mode;
        logic        lfe_present;
        logic [2:0]  channel_count;
    } hdr_result_t;

    // Sample rate in hertz for a valid rate code.
    function automatic logic [15:0] rate_hz(input logic [1:0] rate);
        logic [15:0] hz;
        begin
            case (rate)
                2'd0:    hz = 16'd48000;
                2'd1:    hz = 16'd44100;
                2'd2:    hz = 16'd32000;
                default: hz = 16'd0;
            endcase
            return hz;
        end
    endfunction

    // Full-bandwidth channels for each audio coding mode.
    function automatic logic [2:0] mode_channels(input logic [2:0] acmod);
        logic [2:0] ch;
        begin
            case (acmod)
                3'd0:    ch = 3'd2;
                3'd1:    ch = 3'd1;
                3'd2:    ch = 3'd2;
                3'd3:    ch = 3'd3;
                3'd4:    ch = 3'd3;
                3'd5:    ch = 3'd4;
                3'd6:    ch = 3'd4;
                default: ch = 3'd5;
            endcase
            return ch;
        end
    endfunction

    // Frame length in 16-bit words, by size code and rate code.
    function automatic logic [10:0] frame_words(input logic [5:0] size,
                                                input logic [1:0] rate);
        logic [10:0] w48;
        logic [10:0] w44;
        logic [10:0] w32;
        logic [10:0] w;
        begin
            case (size)
                6'd0:    begin w48 = 11'd64;   w44 = 11'd69;   w32 = 11'd96;   end
                6'd1:    begin w48 = 11'd64;   w44 = 11'd70;   w32 = 11'd96;   end
                6'd2:    begin w48 = 11'd80;   w44 = 11'd87;   w32 = 11'd120;  end
                6'd3:    begin w48 = 11'd80;   w44 = 11'd88;   w32 = 11'd120;  end
                6'd4:    begin w48 = 11'd96;   w44 = 11'd104;  w32 = 11'd144;  end
                6'd5:    begin w48 = 11'd96;   w44 = 11'd105;  w32 = 11'd144;  end
                6'd6:    begin w48 = 11'd112;  w44 = 11'd121;  w32 = 11'd168;  end
                6'd7:    begin w48 = 11'd112;  w44 = 11'd122;  w32 = 11'd168;  end
                6'd8:    begin w48 = 11'd128;  w44 = 11'd139;  w32 = 11'd192;  end
                6'd9:    begin w48 = 11'd128;  w44 = 11'd140;  w32 = 11'd192;  end
                6'd10:   begin w48 = 11'd160;  w44 = 11'd174;  w32 = 11'd240;  end
                6'd11:   begin w48 = 11'd160;  w44 = 11'd175;  w32 = 11'd240;  end
                6'd12:   begin w48 = 11'd192;  w44 = 11'd208;  w32 = 11'd288;  end
                6'd13:   begin w48 = 11'd192;  w44 = 11'd209;  w32 = 11'd288;  end
                6'd14:   begin w48 = 11'd224;  w44 = 11'd243;  w32 = 11'd336;  end
                6'd15:   begin w48 = 11'd224;  w44 = 11'd244;  w32 = 11'd336;  end
                6'd16:   begin w48 = 11'd256;  w44 = 11'd278;  w32 = 11'd384;  end
                6'd17:   begin w48 = 11'd256;  w44 = 11'd279;  w32 = 11'd384;  end
                6'd18:   begin w48 = 11'd320;  w44 = 11'd348;  w32 = 11'd480;  end
                6'd19:   begin w48 = 11'd320;  w44 = 11'd349;  w32 = 11'd480;  end
                6'd20:   begin w48 = 11'd384;  w44 = 11'd417;  w32 = 11'd576;  end
                6'd21:   begin w48 = 11'd384;  w44 = 11'd418;  w32 = 11'd576;  end
                6'd22:   begin w48 = 11'd448;  w44 = 11'd487;  w32 = 11'd672;  end
                6'd23:   begin w48 = 11'd448;  w44 = 11'd488;  w32 = 11'd672;  end
                6'd24:   begin w48 = 11'd512;  w44 = 11'd557;  w32 = 11'd768;  end
                6'd25:   begin w48 = 11'd512;  w44 = 11'd558;  w32 = 11'd768;  end
                6'd26:   begin w48 = 11'd640;  w44 = 11'd696;  w32 = 11'd960;  end
                6'd27:   begin w48 = 11'd640;  w44 = 11'd697;  w32 = 11'd960;  end
                6'd28:   begin w48 = 11'd768;  w44 = 11'd835;  w32 = 11'd1152; end
                6'd29:   begin w48 = 11'd768;  w44 = 11'd836;  w32 = 11'd1152; end
                6'd30:   begin w48 = 11'd896;  w44 = 11'd975;  w32 = 11'd1344; end
                6'd31:   begin w48 = 11'd896;  w44 = 11'd976;  w32 = 11'd1344; end
                6'd32:   begin w48 = 11'd1024; w44 = 11'd1114; w32 = 11'd1536; end
                6'd33:   begin w48 = 11'd1024; w44 = 11'd1115; w32 = 11'd1536; end
                6'd34:   begin w48 = 11'd1152; w44 = 11'd1253; w32 = 11'd1728; end
                6'd35:   begin w48 = 11'd1152; w44 = 11'd1254; w32 = 11'd1728; end
                6'd36:   begin w48 = 11'd1280; w44 = 11'd1393; w32 = 11'd1920; end
                6'd37:   begin w48 = 11'd1280; w44 = 11'd1394; w32 = 11'd1920; end
                default: begin w48 = 11'd0;    w44 = 11'd0;    w32 = 11'd0;    end
            endcase
            case (rate)
                2'd0:    w = w48;
                2'd1:    w = w44;
                2'd2:    w = w32;
                default: w = 11'd0;
            endcase
            return w;
        end
    endfunction

endpackage

// ===== src/ac3_sync_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// AC-3 sync and header parser
// Hunts a programmable 16-bit sync word in a byte stream and reports the
// sample rate, frame length and channel layout of each header found.
// - Input channel (in_valid/in_ready): one stream byte per request, with
//   end_of_stream marking the end of the stream (its byte is ignored).
// - Output channel (out_valid/out_ready): one result per header, or one
//   status-only result when the stream ends inside a header.
// - Each byte is registered on entry and processed from the input register
//   by a single pass of short logic into the result register, so a result
//   is registered after the last header byte passes the input register.
// - Throughput is one byte per cycle while the output does not stall; the
//   rate is set by the per-byte phase update from input to result register.
// - A stall on the output holds the result register and, once the input
//   register is full, drops in_ready until the result is taken.
// - Reset clears the pipeline, returns the parser to sync hunting and
//   loads the default sync word 0x0B77.
// - The sync_word register lies at address 0 of the APB port and should be
//   written only while the parser is idle.
// ----------------------------------------------------------------------------
module ac3_sync_header_parser_unit
    import ac3_hdr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    // Byte stream input.
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_stream,

    // Header results.
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [15:0]           sampling_hz,
    output logic [11:0]           frame_bytes,
    output logic [2:0]            channel_mode,
    output logic                  lfe_present,
    output logic [2:0]            channel_count
);

    // Header byte positions after the sync word.
    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_CRC1  = 3'd1;
    localparam logic [2:0] PH_CRC2  = 3'd2;
    localparam logic [2:0] PH_RATE  = 3'd3;
    localparam logic [2:0] PH_SPARE = 3'd4;
    localparam logic [2:0] PH_MODE  = 3'd5;
    localparam logic [2:0] PH_LAST  = 3'd6;

    logic [15:0]  sync_word_reg;
    logic         in_valid_reg;
    logic [7:0]   byte_reg;
    logic         eos_reg;
    logic [15:0]  sync_shift_reg;
    logic [15:0]  sync_shift_next;
    logic [2:0]   phase_reg;
    logic [2:0]   phase_next;
    logic [1:0]   rate_code_reg;
    logic [1:0]   rate_code_next;
    logic [5:0]   size_code_reg;
    logic [5:0]   size_code_next;
    logic [7:0]   mode_byte_reg;
    logic [7:0]   mode_byte_next;
    logic         out_valid_reg;
    hdr_result_t  out_reg;
    hdr_result_t  out_next;
    hdr_result_t  hdr_result;
    logic         advance;
    logic         emit;
    logic [15:0]  shifted;

    // Configuration register: the sync word is the only register, at address 0.
    assign pready = 1'b1;
    assign prdata = {{(APB_DATA_W-16){1'b0}}, sync_word_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg <= SYNC_WORD_RESET;
        end
        else if (psel && penable && pwrite && (paddr == SYNC_WORD_ADDR))
        begin
            sync_word_reg <= pwdata[15:0];
        end
    end

    // The held byte is processed whenever the result register has room.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
            eos_reg  <= end_of_stream;
        end
    end

    ac3_hdr_decode u_decode (
        .rate_code (rate_code_reg),
        .size_code (size_code_reg),
        .mode_byte (mode_byte_reg),
        .last_byte (byte_reg),
        .result    (hdr_result)
    );

    // Per-byte parser step: sync hunt, header capture and re-arming.
    always_comb
    begin
        sync_shift_next = sync_shift_reg;
        phase_next      = phase_reg;
        rate_code_next  = rate_code_reg;
        size_code_next  = size_code_reg;
        mode_byte_next  = mode_byte_reg;
        emit            = 1'b0;
        out_next        = hdr_result;
        shifted         = {sync_shift_reg[7:0], byte_reg};
        if (eos_reg)
        begin
            sync_shift_next = 16'd0;
            phase_next      = PH_HUNT;
            emit            = (phase_reg != PH_HUNT);
            out_next        = '0;
            out_next.status = STATUS_EOS;
        end
        else
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    sync_shift_next = shifted;
                    if (shifted == sync_word_reg)
                    begin
                        phase_next = PH_CRC1;
                    end
                end
                PH_CRC1, PH_CRC2, PH_SPARE:
                begin
                    phase_next = phase_reg + 3'd1;
                end
                PH_RATE:
                begin
                    rate_code_next = byte_reg[7:6];
                    size_code_next = byte_reg[5:0];
                    phase_next     = PH_MODE;
                end
                PH_MODE:
                begin
                    mode_byte_next = byte_reg;
                    phase_next     = PH_LAST;
                end
                PH_LAST:
                begin
                    emit            = 1'b1;
                    sync_shift_next = 16'd0;
                    phase_next      = PH_HUNT;
                end
                default:
                begin
                    sync_shift_next = 16'd0;
                    phase_next      = PH_HUNT;
                end
            endcase
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_shift_reg <= 16'd0;
            phase_reg      <= PH_HUNT;
            rate_code_reg  <= 2'd0;
            size_code_reg  <= 6'd0;
            mode_byte_reg  <= 8'd0;
        end
        else if (advance)
        begin
            sync_shift_reg <= sync_shift_next;
            phase_reg      <= phase_next;
            rate_code_reg  <= rate_code_next;
            size_code_reg  <= size_code_next;
            mode_byte_reg  <= mode_byte_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign sampling_hz   = out_reg.sampling_hz;
    assign frame_bytes   = out_reg.frame_bytes;
    assign channel_mode  = out_reg.channel_mode;
    assign lfe_present   = out_reg.lfe_present;
    assign channel_count = out_reg.channel_count;

endmodule

// ===== src/ac3_hdr_decode.sv =====
// ----------------------------------------------------------------------------
// AC-3 header field decoder
// Turns the captured rate/size byte and the two mode bytes into one header
// result: status, sample rate, frame length, mode, LFE flag, channel count.
// ----------------------------------------------------------------------------
module ac3_hdr_decode
    import ac3_hdr_pkg::*;
(
    input  logic [1:0]  rate_code,
    input  logic [5:0]  size_code,
    input  logic [7:0]  mode_byte,
    input  logic [7:0]  last_byte,
    output hdr_result_t result
);

    logic [15:0] word;
    logic [2:0]  acmod;
    logic [3:0]  skip;
    logic [3:0]  lfe_pos;
    logic        lfe;
    logic [1:0]  status;

    // The LFE flag moves down by two bits for each mixing-level field present.
    always_comb
    begin
        word  = {mode_byte, last_byte};
        acmod = word[15:13];
        skip  = 4'd3;
        if (acmod[0] && (acmod != ACMOD_MONO))
        begin
            skip = skip + 4'd2;
        end
        if (acmod[2])
        begin
            skip = skip + 4'd2;
        end
        if (acmod == ACMOD_STEREO)
        begin
            skip = skip + 4'd2;
        end
        lfe_pos = 4'd15 - skip;
        lfe     = word[lfe_pos];
    end

    // A reserved rate code outranks a bad size code.
    always_comb
    begin
        if (rate_code == RATE_RESERVED)
        begin
            status = STATUS_BAD_RATE;
        end
        else if (size_code > MAX_SIZE_CODE)
        begin
            status = STATUS_BAD_SIZE;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    // Numeric fields are zero whenever the header is flagged.
    always_comb
    begin
        result.status       = status;
        result.channel_mode = acmod;
        result.lfe_present  = lfe;
        if (status == STATUS_OK)
        begin
            result.sampling_hz   = rate_hz(rate_code);
            result.frame_bytes   = {frame_words(size_code, rate_code), 1'b0};
            result.channel_count = mode_channels(acmod) + {2'b00, lfe};
        end
        else
        begin
            result.sampling_hz   = 16'd0;
            result.frame_bytes   = 12'd0;
            result.channel_count = 3'd0;
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AC-3 sync and header parser testbench
// Feeds byte streams built from whole, cut-short and noisy AC-3 headers into
// the parser under random sender gaps and receiver stalls. It moves the sync
// word through several settings between phases. A scoreboard predicts every
// header result and checks the fields of each result the parser returns.
// ----------------------------------------------------------------------------
module testbench;
    import ac3_hdr_pkg::*;

    // Parser position within one header, counted in bytes after the sync word.
    typedef enum logic [2:0] {
        HUNT      = 3'd0,
        CRC_HI    = 3'd1,
        CRC_LO    = 3'd2,
        RATE_SIZE = 3'd3,
        BSID      = 3'd4,
        MODE_HI   = 3'd5,
        MODE_LO   = 3'd6
    } hdr_phase_e;

    // Rate codes that select a table column.
    localparam logic [1:0] RATE_44K = 2'd1;
    localparam logic [1:0] RATE_32K = 2'd2;

    // Cycles without any accepted byte or taken result before the run is declared hung.
    localparam int IDLE_LIMIT = 2000;

    // Bytes of random stimulus in each sync word phase.
    localparam int PHASE_BYTES = 125;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the parser state and queues the headers it will emit.
    // ------------------------------------------------------------------------
    class header_scoreboard;
        logic [15:0] sync_word;
        logic [15:0] sync_shift;
        hdr_phase_e  phase;
        logic [1:0]  rate_code;
        logic [5:0]  size_code;
        logic [7:0]  mode_hi;
        hdr_result_t expected_q[$];
        int          mismatches;
        logic [15:0] rate_hz_tab[3];
        logic [10:0] words48_tab[19];
        logic [10:0] words44_tab[19];
        logic [2:0]  mode_ch_tab[8];

        function new();
            sync_word  = SYNC_WORD_RESET;
            sync_shift = '0;
            phase      = HUNT;
            rate_code  = '0;
            size_code  = '0;
            mode_hi    = '0;
            mismatches = 0;
            rate_hz_tab = '{16'd48000, 16'd44100, 16'd32000};
            // Size codes come in pairs; the 48 kHz word is shared by a pair.
            words48_tab = '{64, 80, 96, 112, 128, 160, 192, 224, 256, 320,
                            384, 448, 512, 640, 768, 896, 1024, 1152, 1280};
            // At 44.1 kHz the odd code of a pair carries one extra word.
            words44_tab = '{69, 87, 104, 121, 139, 174, 208, 243, 278, 348,
                            417, 487, 557, 696, 835, 975, 1114, 1253, 1393};
            mode_ch_tab = '{3'd2, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5};
        endfunction

        function void rearm();
            phase      = HUNT;
            sync_shift = '0;
        endfunction

        // Build the result for the last header byte.
        function hdr_result_t decode_header(input logic [7:0] lo);
            hdr_result_t r;
            logic [15:0] word;
            logic [10:0] words;
            int          skip;
            word = {mode_hi, lo};
            r = '0;
            r.channel_mode = word[15:13];
            // The LFE bit moves down past the mixing-level fields of the mode.
            skip = 3;
            if (r.channel_mode[0] && r.channel_mode != ACMOD_MONO) skip += 2;
            if (r.channel_mode[2]) skip += 2;
            if (r.channel_mode == ACMOD_STEREO) skip += 2;
            r.lfe_present = word[15 - skip];
            if (rate_code == RATE_RESERVED) begin
                r.status = STATUS_BAD_RATE;
            end
            else if (size_code > MAX_SIZE_CODE) begin
                r.status = STATUS_BAD_SIZE;
            end
            else begin
                r.status = STATUS_OK;
                if (rate_code == RATE_44K)
                    words = words44_tab[size_code[5:1]] + size_code[0];
                else
                    words = words48_tab[size_code[5:1]];
                // The 32 kHz frame is one and a half times the 48 kHz one.
                if (rate_code == RATE_32K) words = words + (words >> 1);
                r.sampling_hz   = rate_hz_tab[rate_code];
                r.frame_bytes   = {words, 1'b0};
                r.channel_count = mode_ch_tab[r.channel_mode] + r.lfe_present;
            end
            return r;
        endfunction

        // Step the parser state by one accepted stream byte.
        function void take_byte(input logic [7:0] b, input logic eos);
            hdr_result_t r;
            if (eos) begin
                if (phase != HUNT) begin
                    r = '0;
                    r.status = STATUS_EOS;
                    expected_q.push_back(r);
                end
                rearm();
                return;
            end
            case (phase)
                HUNT: begin
                    sync_shift = {sync_shift[7:0], b};
                    if (sync_shift == sync_word) phase = CRC_HI;
                end
                CRC_HI: phase = CRC_LO;
                CRC_LO: phase = RATE_SIZE;
                // The rate/size byte leads straight into the mode bytes.
                RATE_SIZE: begin
                    rate_code = b[7:6];
                    size_code = b[5:0];
                    phase     = MODE_HI;
                end
                BSID: phase = MODE_HI;
                MODE_HI: begin
                    mode_hi = b;
                    phase   = MODE_LO;
                end
                MODE_LO: begin
                    expected_q.push_back(decode_header(b));
                    rearm();
                end
                default: rearm();
            endcase
        endfunction

        task report_mismatch(input string what);
            $display("%0t mismatch: %s", $time, what);
            mismatches++;
        endtask

        task compare_field(input string name, input logic [15:0] got,
                           input logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        endtask

        // Compare one returned header with the oldest prediction.
        task check_header(input hdr_result_t got);
            hdr_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with status %0d not expected",
                                          got.status));
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("sampling_hz", got.sampling_hz, want.sampling_hz);
            compare_field("frame_bytes", got.frame_bytes, want.frame_bytes);
            compare_field("channel_mode", got.channel_mode, want.channel_mode);
            compare_field("lfe_present", got.lfe_present, want.lfe_present);
            compare_field("channel_count", got.channel_count, want.channel_count);
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals, clock and the parser instance.
    // ------------------------------------------------------------------------
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [7:0]            data_byte     = '0;
    logic                  end_of_stream = 1'b0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic [1:0]            status;
    logic [15:0]           sampling_hz;
    logic [11:0]           frame_bytes;
    logic [2:0]            channel_mode;
    logic                  lfe_present;
    logic [2:0]            channel_count;

    logic                  in_fire;
    logic                  out_fire;
    int                    idle_cycles   = 0;
    int                    bytes_sent    = 0;
    bit                    calm          = 1'b0;
    logic [15:0]           cur_sync      = SYNC_WORD_RESET;
    header_scoreboard      sb            = new();

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always #5 clk = ~clk;

    ac3_sync_header_parser_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .sampling_hz   (sampling_hz),
        .frame_bytes   (frame_bytes),
        .channel_mode  (channel_mode),
        .lfe_present   (lfe_present),
        .channel_count (channel_count)
    );

    // ------------------------------------------------------------------------
    // Stimulus tasks.
    // ------------------------------------------------------------------------

    // Idle cycles before the next request; none during calm stretches.
    function automatic int draw_gap();
        if (calm) return 0;
        return $urandom_range(0, 11);
    endfunction

    // Offer one stream byte and hold it until the request is taken.
    task automatic send_byte(input logic [7:0] b, input bit eos);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_stream <= eos;
        do @(posedge clk); while (!in_ready);
        if (!eos) bytes_sent++;
    endtask

    // Send a sync word and up to five header bytes; a cut header ends the stream.
    task automatic send_header(input logic [7:0] rate_size, input logic [7:0] hi,
                               input logic [7:0] lo, input int keep,
                               input bit short_sync);
        logic [7:0] body[5];
        body = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 rate_size, hi, lo};
        if (!short_sync) send_byte(cur_sync[15:8], 1'b0);
        send_byte(cur_sync[7:0], 1'b0);
        for (int i = 0; i < keep; i++) send_byte(body[i], 1'b0);
        if (keep < 5) send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Hold the sender until every predicted result has been returned.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // APB write of the sync word: setup cycle, then access cycle.
    task automatic write_sync(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SYNC_WORD_ADDR;
        pwdata  <= {{(APB_DATA_W - 16){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        sb.sync_word = value;
        cur_sync     = value;
    endtask

    // Random rate/size byte, mostly with a legal size code.
    function automatic logic [7:0] draw_rate_size();
        logic [1:0] rate;
        logic [5:0] size;
        rate = 2'($urandom_range(0, 3));
        size = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(38, 63))
                                           : 6'($urandom_range(0, 37));
        return {rate, size};
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: feeds accepted bytes to the scoreboard and checks results.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_fire) sb.take_byte(data_byte, end_of_stream);
            if (out_fire)
                sb.check_header({status, sampling_hz, frame_bytes, channel_mode,
                                 lfe_present, channel_count});
            idle_cycles <= (in_fire || out_fire) ? 0 : idle_cycles + 1;
        end
    end

    // Receiver: stalls a random number of cycles before each result.
    initial begin : result_sink
        int stall;
        wait (rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_fire);
        end
    end

    // Hang detection.
    initial begin : watchdog
        wait (rst_n);
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: directed headers, then random phases per sync word.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [15:0] sync_list[6];
        int          target;
        int          pick;
        bit          short_sync;
        sync_list = '{SYNC_WORD_RESET, 16'h0000, 16'hFFFF, 16'h00A5,
                      16'($urandom_range(0, 65535)), SYNC_WORD_RESET};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed headers under the reset sync word.
        send_byte(8'hFF, 1'b1);                         // end of stream while hunting
        send_header(8'h00, 8'h00, 8'h00, 5, 1'b0);      // all-zero header, 48 kHz
        send_header(8'hA5, 8'hFF, 8'hFF, 5, 1'b0);      // 32 kHz, top size, 3/2 with LFE
        send_header(8'h40, 8'h41, 8'h00, 5, 1'b0);      // 44.1 kHz stereo without LFE
        send_header(8'hFF, 8'h60, 8'h00, 5, 1'b0);      // reserved rate over bad size
        send_header(8'h66, 8'h80, 8'h00, 5, 1'b0);      // first bad size code
        send_header(8'h25, 8'h30, 8'hA5, 2, 1'b0);      // stream ends inside a header
        drain_results();

        // Random phases; each starts from an idle parser hunting for sync.
        foreach (sync_list[p]) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            drain_results();
            repeat (4) @(posedge clk);
            write_sync(sync_list[p]);
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                calm       = ($urandom_range(0, 5) == 0);
                pick       = $urandom_range(0, 9);
                // A zero high byte can match on its low byte alone after re-arm.
                short_sync = (cur_sync[15:8] == 8'h00) && ($urandom_range(0, 1) == 1);
                if (pick < 7) begin
                    send_header(draw_rate_size(), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 5, short_sync);
                end
                else if (pick == 7) begin
                    send_header(draw_rate_size(), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), $urandom_range(0, 4),
                                short_sync);
                end
                else if (pick == 8) begin
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                else begin
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                end
                if ($urandom_range(0, 11) == 0) drain_results();
            end
        end

        // Let the last results come back and give the parser time to settle.
        calm = 1'b0;
        drain_results();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
